/* rtl/core/ccfr_pkg.sv */
// ----------------------------------------------------------------------------
// ccfr_pkg: shared types and constants of the command frame receiver
// Item and result layouts, result kinds, register indexes and reset values.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  // default width of the inter-byte tick counter and its limit register
  localparam int unsigned TIMEOUT_WIDTH_DEFAULT = 20;

  // reset values of the configuration registers
  localparam logic [7:0]  SYNC_BYTE_RESET     = 8'h2F;
  localparam int unsigned TIMEOUT_TICKS_RESET = 100000;
  // the timeout register field is at most 20 bits wide
  localparam logic [31:0] TIMEOUT_FIELD_MASK  = 32'h000F_FFFF;

  // crc16-xmodem generator
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // count code zero stands for the largest frame
  localparam logic [8:0] PARAM_TOTAL_MAX = 9'd256;

  // configuration register indexes
  localparam logic CFG_SYNC_BYTE     = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  // input item mode
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_PARAM   = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  command;
    logic [15:0] address;
    logic [8:0]  param_total;
    logic [7:0]  param_index;
    logic [7:0]  param_byte;
  } out_item_t;

  // result of one parser step
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

/* rtl/core/ccfr_chan_if.sv */
// ----------------------------------------------------------------------------
// ccfr_chan_if: valid/ready channel
// One transfer at each rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ccfr_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ccfr_parser.sv */
// ----------------------------------------------------------------------------
// ccfr_parser: frame state machine and crc check
// Consumes one byte or tick per step and produces at most one result.
// ----------------------------------------------------------------------------
module ccfr_parser
  import ccfr_pkg::*;
#(
  parameter int unsigned TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  in_item_t                 item,
  input  logic [7:0]               sync_byte,
  input  logic [TIMEOUT_WIDTH-1:0] timeout_ticks,
  output step_res_t                res
);

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_HEADER   = 5'b00010,
    PH_PARAMS   = 5'b00100,
    PH_CRC_HIGH = 5'b01000,
    PH_CRC_LOW  = 5'b10000
  } phase_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  phase_t                   phase_r, phase_nxt;
  logic [1:0]               hdr_pos_r, hdr_pos_nxt;
  logic [7:0]               cmd_r, cmd_nxt;
  logic [15:0]              addr_r, addr_nxt;
  logic [8:0]               len_r, len_nxt;
  logic [7:0]               par_pos_r, par_pos_nxt;
  logic [15:0]              crc_r, crc_nxt;
  logic [7:0]               crc_hi_r, crc_hi_nxt;
  logic [TIMEOUT_WIDTH-1:0] tick_cnt_r, tick_cnt_nxt;

  logic [TIMEOUT_WIDTH-1:0] tick_inc;
  logic [TIMEOUT_WIDTH-1:0] limit;
  logic                     timed_out;
  logic [15:0]              crc_upd;
  logic [7:0]               b;

  assign b         = item.data_byte;
  assign tick_inc  = tick_cnt_r + 1'b1;
  assign limit     = (timeout_ticks == '0) ? TIMEOUT_WIDTH'(1) : timeout_ticks;
  assign timed_out = (tick_inc >= limit) || (tick_inc == '0);
  assign crc_upd   = crc_byte((phase_r == PH_IDLE) ? 16'h0000 : crc_r, b);

  always_comb begin
    phase_nxt    = phase_r;
    hdr_pos_nxt  = hdr_pos_r;
    cmd_nxt      = cmd_r;
    addr_nxt     = addr_r;
    len_nxt      = len_r;
    par_pos_nxt  = par_pos_r;
    crc_nxt      = crc_r;
    crc_hi_nxt   = crc_hi_r;
    tick_cnt_nxt = tick_cnt_r;

    res.valid            = 1'b0;
    res.item.kind        = KIND_PARAM;
    res.item.command     = cmd_r;
    res.item.address     = addr_r;
    res.item.param_total = len_r;
    res.item.param_index = 8'h00;
    res.item.param_byte  = 8'h00;

    if (step) begin
      if (item.mode == MODE_TICK) begin
        if (phase_r != PH_IDLE) begin
          tick_cnt_nxt = tick_inc;
          if (timed_out) begin
            res.valid     = 1'b1;
            res.item.kind = KIND_ABORT;
            phase_nxt     = PH_IDLE;
            tick_cnt_nxt  = '0;
          end
        end
      end else begin
        tick_cnt_nxt = '0;
        case (phase_r)
          PH_IDLE: begin
            if (b == sync_byte) begin
              phase_nxt   = PH_HEADER;
              hdr_pos_nxt = 2'd0;
              cmd_nxt     = 8'h00;
              addr_nxt    = 16'h0000;
              len_nxt     = 9'd0;
              par_pos_nxt = 8'h00;
              crc_hi_nxt  = 8'h00;
              crc_nxt     = crc_upd;
            end
          end
          PH_HEADER: begin
            crc_nxt     = crc_upd;
            hdr_pos_nxt = hdr_pos_r + 2'd1;
            case (hdr_pos_r)
              2'd0:    cmd_nxt = b;
              2'd1:    addr_nxt = {b, addr_r[7:0]};
              2'd2:    addr_nxt = {addr_r[15:8], b};
              default: begin
                len_nxt     = (b == 8'h00) ? PARAM_TOTAL_MAX : {1'b0, b};
                par_pos_nxt = 8'h00;
                phase_nxt   = PH_PARAMS;
              end
            endcase
          end
          PH_PARAMS: begin
            crc_nxt              = crc_upd;
            res.valid            = 1'b1;
            res.item.kind        = KIND_PARAM;
            res.item.param_index = par_pos_r;
            res.item.param_byte  = b;
            if (({1'b0, par_pos_r} + 9'd1) >= len_r) begin
              phase_nxt = PH_CRC_HIGH;
            end
            par_pos_nxt = par_pos_r + 8'd1;
          end
          PH_CRC_HIGH: begin
            crc_hi_nxt = b;
            phase_nxt  = PH_CRC_LOW;
          end
          PH_CRC_LOW: begin
            res.valid     = 1'b1;
            res.item.kind = ({crc_hi_r, b} == crc_r) ? KIND_ACCEPT : KIND_CRC_ERR;
            phase_nxt     = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hdr_pos_r  <= 2'd0;
      cmd_r      <= 8'h00;
      addr_r     <= 16'h0000;
      len_r      <= 9'd0;
      par_pos_r  <= 8'h00;
      crc_r      <= 16'h0000;
      crc_hi_r   <= 8'h00;
      tick_cnt_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      cmd_r      <= cmd_nxt;
      addr_r     <= addr_nxt;
      len_r      <= len_nxt;
      par_pos_r  <= par_pos_nxt;
      crc_r      <= crc_nxt;
      crc_hi_r   <= crc_hi_nxt;
      tick_cnt_r <= tick_cnt_nxt;
    end
  end

  // the tick counter only runs inside a frame
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_cnt_r == '0))
    else $error("tick counter nonzero while idle");

  // a timeout abort always lands the parser back in idle
  a_abort_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.item.kind == KIND_ABORT) |=> (phase_r == PH_IDLE))
    else $error("abort did not return to idle");

  // parameter results only come out of the parameter phase
  a_param_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.item.kind == KIND_PARAM) |-> (phase_r == PH_PARAMS))
    else $error("parameter result outside parameter phase");

endmodule

/* rtl/core/crc_checked_command_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc_checked_command_frame_receiver: framed command receiver, crc16 check
// Parses sync, header, parameters and crc; reports parameters and frame status.
// ----------------------------------------------------------------------------
// Takes one input transfer per clock (a received byte or a timer tick) and
// gives at most one result transfer for it, after it passes the input register
// and then the result register. With the result side ready, input is taken
// every cycle; a stalled result holds one item in the input register and drops
// in_ch.ready until the result register drains. The per-byte crc16-xmodem
// update and the frame state machine sit as combinational logic between those
// two registers. Configuration writes on the cfg_ port take effect at once and
// are meant for when the block is idle.
module crc_checked_command_frame_receiver
  import ccfr_pkg::*;
#(
  parameter int unsigned TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  ccfr_chan_if.sink                in_ch,
  ccfr_chan_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [TIMEOUT_WIDTH-1:0] cfg_wdata
);

  localparam logic [TIMEOUT_WIDTH-1:0] TicksReset = TIMEOUT_WIDTH'(TIMEOUT_TICKS_RESET);
  localparam logic [TIMEOUT_WIDTH-1:0] TicksMask  = TIMEOUT_WIDTH'(TIMEOUT_FIELD_MASK);

  // configuration registers
  logic [7:0]               sync_byte_r, sync_byte_nxt;
  logic [TIMEOUT_WIDTH-1:0] timeout_r, timeout_nxt;

  // input register
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic      in_xfer;
  logic      advance;
  step_res_t res;

  // the held item moves on when the result register is free or draining
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

  // register writes
  always_comb begin
    sync_byte_nxt = sync_byte_r;
    timeout_nxt   = timeout_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_BYTE:     sync_byte_nxt = cfg_wdata[7:0];
        CFG_TIMEOUT_TICKS: timeout_nxt = cfg_wdata & TicksMask;
        default:           sync_byte_nxt = sync_byte_r;
      endcase
    end
  end

  // valid bits of the two stages
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.valid;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  ccfr_parser #(
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .item          (in_item_r),
    .sync_byte     (sync_byte_r),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r <= SYNC_BYTE_RESET;
      timeout_r   <= TicksReset;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sync_byte_r <= sync_byte_nxt;
      timeout_r   <= timeout_nxt;
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_ch.data;
    end
    if (advance && res.valid) begin
      out_item_r <= res.item;
    end
  end

  // a held item is never dropped while the result side stalls
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ch.ready) |=> in_valid_r)
    else $error("held input item lost during stall");

  // ready only drops with an item waiting in the input register
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r))
    else $error("input stalled without a pending item");

  // a result made by the parser is shown on the next cycle
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid) |=> out_ch.valid)
    else $error("parser result not presented");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the crc checked command frame receiver
// Streams framed commands, stray bytes and timer ticks into the block, predicts
// every parameter, status and abort result, and checks each result transfer in
// order. Both sides idle at random, the result side once holds off for a long
// stretch, and the sync byte and timeout registers are changed between phases.
// ----------------------------------------------------------------------------
module tb;
  import ccfr_pkg::*;

  localparam int TW           = TIMEOUT_WIDTH_DEFAULT;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4;      // input register plus result register, with margin
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_ITEMS  = 130;

  // receiver position within a frame
  typedef enum logic [2:0] {
    RX_IDLE,
    RX_HEADER,
    RX_PARAMS,
    RX_CRC_HI,
    RX_CRC_LO
  } rx_phase_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_we;
  logic          cfg_index;
  logic [TW-1:0] cfg_wdata;

  ccfr_chan_if #(.T(in_item_t))  in_ch ();
  ccfr_chan_if #(.T(out_item_t)) out_ch ();

  crc_checked_command_frame_receiver #(
    .TIMEOUT_WIDTH(TW)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // predicted receiver state and register copies
  // --------------------------------------------------------------------------
  logic [7:0]    sync_cfg  = SYNC_BYTE_RESET;
  logic [TW-1:0] tmo_cfg   = TW'(TIMEOUT_TICKS_RESET);
  rx_phase_t     rx_phase  = RX_IDLE;
  logic [1:0]    hdr_pos   = '0;
  logic [7:0]    frm_cmd   = '0;
  logic [15:0]   frm_addr  = '0;
  logic [8:0]    frm_len   = '0;
  logic [7:0]    par_pos   = '0;
  logic [15:0]   crc_acc   = '0;
  logic [7:0]    crc_hi_rx = '0;
  logic [TW-1:0] tick_cnt  = '0;

  out_item_t pending_results[$];   // results still owed by the block
  in_item_t  link_q[$];            // bytes and ticks waiting to be sent
  logic [7:0] par_buf[$];          // fixed parameters for the next frame

  int unsigned stim_items;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned rcv_gap;
  int unsigned hold_left;
  bit          send_idle_on;
  bit          rcv_idle_on;
  bit          hold_req;
  bit          in_fire;
  bit          out_fire;

  // crc16-xmodem, one byte msb first
  function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic out_item_t frame_result(kind_t k, logic [7:0] idx, logic [7:0] pb);
    out_item_t r;
    r.kind        = k;
    r.command     = frm_cmd;
    r.address     = frm_addr;
    r.param_total = frm_len;
    r.param_index = idx;
    r.param_byte  = pb;
    return r;
  endfunction

  // advances the predicted receiver by one byte or tick
  function automatic void parse_item(input in_item_t it, output logic has,
                                     output out_item_t res);
    logic [TW-1:0] lim;
    logic [7:0]    b;
    has = 1'b0;
    res = '0;
    b   = it.data_byte;
    if (it.mode == MODE_TICK) begin
      // ticks only count inside a frame; a zero limit acts as one
      if (rx_phase != RX_IDLE) begin
        lim      = (tmo_cfg == '0) ? TW'(1) : tmo_cfg;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= lim || tick_cnt == '0) begin
          res      = frame_result(KIND_ABORT, 8'h00, 8'h00);
          has      = 1'b1;
          rx_phase = RX_IDLE;
          tick_cnt = '0;
        end
      end
    end else begin
      tick_cnt = '0;
      case (rx_phase)
        RX_IDLE: begin
          if (b == sync_cfg) begin
            rx_phase  = RX_HEADER;
            hdr_pos   = '0;
            frm_cmd   = '0;
            frm_addr  = '0;
            frm_len   = '0;
            par_pos   = '0;
            crc_hi_rx = '0;
            crc_acc   = crc16_next(16'h0000, b);
          end
        end
        RX_HEADER: begin
          crc_acc = crc16_next(crc_acc, b);
          case (hdr_pos)
            2'd0: frm_cmd = b;
            2'd1: frm_addr[15:8] = b;
            2'd2: frm_addr[7:0] = b;
            default: begin
              frm_len  = (b == 8'h00) ? PARAM_TOTAL_MAX : {1'b0, b};
              par_pos  = '0;
              rx_phase = RX_PARAMS;
            end
          endcase
          hdr_pos = hdr_pos + 1'b1;
        end
        RX_PARAMS: begin
          crc_acc = crc16_next(crc_acc, b);
          res     = frame_result(KIND_PARAM, par_pos, b);
          has     = 1'b1;
          if (int'(par_pos) + 1 >= int'(frm_len))
            rx_phase = RX_CRC_HI;
          par_pos = par_pos + 1'b1;
        end
        RX_CRC_HI: begin
          crc_hi_rx = b;
          rx_phase  = RX_CRC_LO;
        end
        RX_CRC_LO: begin
          res      = frame_result(({crc_hi_rx, b} == crc_acc) ? KIND_ACCEPT : KIND_CRC_ERR,
                                  8'h00, 8'h00);
          has      = 1'b1;
          rx_phase = RX_IDLE;
        end
        default: rx_phase = RX_IDLE;
      endcase
    end
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("kind %0d cmd %02h addr %04h count %0d index %0d byte %02h",
                     r.kind, r.command, r.address, r.param_total, r.param_index,
                     r.param_byte);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int cur_tick_limit();
    return (tmo_cfg == '0) ? 1 : int'(tmo_cfg);
  endfunction

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.mode      = MODE_BYTE;
    it.data_byte = b;
    link_q.push_back(it);
    stim_items++;
  endtask

  // the byte lane of a tick is don't-care, so it carries random bits
  task automatic push_tick();
    in_item_t it;
    it.mode      = MODE_TICK;
    it.data_byte = 8'($urandom);
    link_q.push_back(it);
    stim_items++;
  endtask

  // one frame from the current sync byte; cut_len 0 sends it whole, a positive
  // value sends that many bytes and -1 a random prefix, then ticks until abort
  task automatic add_frame(logic [7:0] cmd, logic [15:0] addr, logic [7:0] code,
                           bit bad_crc, int cut_len, bit mix_ticks);
    logic [7:0]  fb[$];
    logic [15:0] crc;
    int          n;
    int          lim;
    int          sent;
    int          k;
    lim = cur_tick_limit();
    n   = (code == 8'h00) ? 256 : int'(code);
    fb.push_back(sync_cfg);
    fb.push_back(cmd);
    fb.push_back(addr[15:8]);
    fb.push_back(addr[7:0]);
    fb.push_back(code);
    while (par_buf.size() < n)
      par_buf.push_back(8'($urandom));
    for (int i = 0; i < n; i++)
      fb.push_back(par_buf[i]);
    par_buf.delete();
    crc = 16'h0000;
    foreach (fb[i])
      crc = crc16_next(crc, fb[i]);
    if (bad_crc)
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(crc[15:8]);
    fb.push_back(crc[7:0]);
    if (cut_len < 0)
      sent = $urandom_range(1, fb.size() - 1);
    else if (cut_len > 0)
      sent = cut_len;
    else
      sent = fb.size();
    for (int i = 0; i < sent; i++) begin
      // a few ticks between bytes, always short of the limit
      if (i > 0 && mix_ticks && lim > 1 && $urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, (lim - 1 < 8) ? lim - 1 : 8);
        repeat (k) push_tick();
      end
      push_byte(fb[i]);
    end
    if (cut_len != 0)
      repeat (lim) push_tick();
  endtask

  // stray bytes and ticks while idle, never the sync value
  task automatic add_noise();
    int         n;
    logic [7:0] b;
    n = $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 1)) begin
        push_tick();
      end else begin
        b = 8'($urandom);
        if (b == sync_cfg)
          b = ~b;
        push_byte(b);
      end
    end
  endtask

  // everything sent, every result back, pipeline empty
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (link_q.size() != 0 || in_ch.valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SYNC_BYTE)
      sync_cfg = val[7:0];
    else
      tmo_cfg = val;
  endtask

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // input driver: one item at a time from link_q, random gap after each transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (link_q.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= link_q.pop_front();
        send_gap = send_idle_on ? $urandom_range(0, 19) : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall after each transfer, plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (out_fire)
        rcv_gap = rcv_idle_on ? $urandom_range(0, 19) : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: check result transfers, then predict from the input transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    logic      has;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_fire  = rst_n && in_ch.valid && in_ch.ready;
      out_fire = rst_n && out_ch.valid && out_ch.ready;
      if (out_fire) begin
        got = out_ch.data;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at cycle %0d: %s", cycle_cnt, fmt_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind || got.command !== want.command ||
              got.address !== want.address || got.param_total !== want.param_total ||
              got.param_index !== want.param_index || got.param_byte !== want.param_byte)
          begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch at cycle %0d", cycle_cnt);
              $display("  expected %s", fmt_result(want));
              $display("  actual   %s", fmt_result(got));
            end
          end
        end
      end
      // an input passes the input and result registers before its result shows, so a result never belongs to this input
      if (in_fire) begin
        parse_item(in_ch.data, has, want);
        if (has)
          pending_results.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequence: reset, directed frames, then random phases with new settings
  // --------------------------------------------------------------------------
  initial begin
    int            p;
    int            f;
    int            start;
    int            r;
    int            lim;
    logic [7:0]    code;
    logic [7:0]    sync;
    logic [TW-1:0] tmo;
    logic [TW-1:0] wval;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SYNC_BYTE;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    send_idle_on = 1'b1;
    rcv_idle_on  = 1'b1;
    hold_req     = 1'b0;
    send_gap     = 0;
    rcv_gap      = 0;
    hold_left    = 0;
    stim_items   = 0;
    cycle_cnt    = 0;
    mismatches   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: idle tick and stray bytes are dropped
    push_tick();
    push_byte(8'h00);
    push_byte(8'hFF);
    // all-ones command and address, single parameter equal to the sync value, good crc
    par_buf.push_back(SYNC_BYTE_RESET);
    add_frame(8'hFF, 16'hFFFF, 8'd1, 1'b0, 0, 1'b1);
    // all-zero command and address, two parameters, corrupted crc
    par_buf.push_back(8'hFF);
    par_buf.push_back(8'h80);
    add_frame(8'h00, 16'h0000, 8'd2, 1'b1, 0, 1'b0);
    wait_idle();

    // timeout of one tick: abort right after the command byte, header partial
    write_reg(CFG_TIMEOUT_TICKS, TW'(1));
    add_frame(8'hA5, 16'h1234, 8'd3, 1'b0, 2, 1'b0);
    push_tick();
    wait_idle();

    // zero timeout acts as one: abort once the header is complete
    write_reg(CFG_TIMEOUT_TICKS, '0);
    add_frame(8'h5A, 16'hBEEF, 8'd4, 1'b0, 5, 1'b0);
    wait_idle();

    // random phases, register extremes first
    stim_items = 0;
    p = 0;
    while (stim_items < RANDOM_ITEMS) begin
      case (p)
        0: begin
          sync = 8'h00;
          tmo  = '1;
        end
        1: begin
          sync = 8'hFF;
          tmo  = TW'(1);
        end
        2: begin
          sync = SYNC_BYTE_RESET;
          tmo  = TW'(TIMEOUT_TICKS_RESET);
        end
        default: begin
          sync = 8'($urandom);
          tmo  = ($urandom_range(0, 9) == 0) ? '0 : TW'($urandom_range(1, 20));
        end
      endcase
      // upper data bits are don't-care for the sync register
      wval      = TW'($urandom);
      wval[7:0] = sync;
      write_reg(CFG_SYNC_BYTE, wval);
      write_reg(CFG_TIMEOUT_TICKS, tmo);
      lim = cur_tick_limit();

      // idling pattern per phase; phase 3 streams into a stalled result side
      send_idle_on = (p % 4) < 2;
      rcv_idle_on  = (p % 4) == 0 || (p % 4) == 2;
      if (p == 3)
        hold_req = 1'b1;

      start = stim_items;
      f = 0;
      while (stim_items - start < PHASE_ITEMS && stim_items < RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 99))
          0:       code = 8'h00;
          1, 2:    code = 8'($urandom_range(7, 255));
          default: code = 8'($urandom_range(1, 6));
        endcase
        // longest frame and largest explicit count once each
        if (p == 4 && f == 0)
          code = 8'h00;
        if (p == 5 && f == 0)
          code = 8'd255;
        if (r < 8)
          add_noise();
        else
          add_frame(8'($urandom), 16'($urandom), code, r < 25,
                    (r >= 85 && lim <= 64) ? -1 : 0, 1'($urandom_range(0, 1)));
        f++;
      end
      // sender holds until every result of the phase is back
      wait_idle();
      p++;
    end

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ccfr_pkg.sv
rtl/core/ccfr_chan_if.sv
rtl/core/ccfr_parser.sv
rtl/core/crc_checked_command_frame_receiver.sv
test/tb.sv
